>>> src/pdfd_pkg.sv
// ----------------------------------------------------------------------------
// PD controller package
// Widths, register indexes, reset values and shared types for the
// filtered-derivative PD controller.
// ----------------------------------------------------------------------------
package pdfd_pkg;

  // Default number of fraction bits of every Q-format value.
  localparam int FRAC_BITS_DEF = 16;

  localparam int REG_W   = 31;   // configuration register width
  localparam int DATA_W  = 32;   // setpoint, measured and drive width
  localparam int ERR_W   = 33;   // error width, one more than the inputs
  localparam int IDX_W   = 3;    // configuration index width
  localparam int MUL_W   = 33;   // operand width of the shared multiplier
  localparam int PROD_W  = 2 * MUL_W;
  localparam int GAIN_W  = 64;   // combined gain width
  // The numerator stays below 2^98 for any fraction count up to 31.
  localparam int ACC_W   = 100;
  localparam int QUOT_W  = 32;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] IDX_PROP_GAIN   = 3'd0;
  localparam logic [IDX_W-1:0] IDX_DERIV_GAIN  = 3'd1;
  localparam logic [IDX_W-1:0] IDX_FILTER_TC   = 3'd2;
  localparam logic [IDX_W-1:0] IDX_SAMPLE_PER  = 3'd3;
  localparam logic [IDX_W-1:0] IDX_DRIVE_LIMIT = 3'd4;

  // Reset values of the registers.
  localparam logic [REG_W-1:0] SAMPLE_PERIOD_RST = 31'd65536;
  localparam logic [REG_W-1:0] DRIVE_LIMIT_RST   = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [REG_W-1:0] prop_gain;
    logic [REG_W-1:0] deriv_gain;
    logic [REG_W-1:0] filter_time_const;
    logic [REG_W-1:0] sample_period;
    logic [REG_W-1:0] drive_limit;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

endpackage

>>> src/pdfd_cfg.sv
// ----------------------------------------------------------------------------
// PD controller configuration registers
// Holds the gains, filter time constant, sample period and output limit.
// ----------------------------------------------------------------------------
module pdfd_cfg import pdfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain         <= '0;
      cfg.deriv_gain        <= '0;
      cfg.filter_time_const <= '0;
      cfg.sample_period     <= SAMPLE_PERIOD_RST;
      cfg.drive_limit       <= DRIVE_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        IDX_PROP_GAIN:   cfg.prop_gain         <= cfg_data;
        IDX_DERIV_GAIN:  cfg.deriv_gain        <= cfg_data;
        IDX_FILTER_TC:   cfg.filter_time_const <= cfg_data;
        IDX_SAMPLE_PER:  cfg.sample_period     <= cfg_data;
        IDX_DRIVE_LIMIT: cfg.drive_limit       <= cfg_data;
        default: begin
          // Indexes past the register list are ignored.
        end
      endcase
    end
  end

endmodule

>>> src/pdfd_mul.sv
// ----------------------------------------------------------------------------
// PD controller shared multiplier
// Unsigned 33 x 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module pdfd_mul import pdfd_pkg::*; (
  input  logic              clk,
  input  logic [MUL_W-1:0]  mul_a,
  input  logic [MUL_W-1:0]  mul_b,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

endmodule

>>> src/pdfd_div.sv
// ----------------------------------------------------------------------------
// PD controller divider
// Restoring divider producing a 32-bit quotient one bit per cycle, with an
// overflow flag when the quotient does not fit in 32 bits.
// ----------------------------------------------------------------------------
module pdfd_div import pdfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ACC_W-1:0]  dividend,
  input  logic [QUOT_W-1:0] divisor,
  output div_res_t          res
);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t             dstate;
  logic [QUOT_W-1:0]   rem;
  logic [QUOT_W-1:0]   quo;
  logic [QUOT_W-1:0]   dvs;
  logic [4:0]          cnt;
  logic [QUOT_W+1:0]   diff;
  logic                qbit;
  logic [QUOT_W-1:0]   rem_next;
  logic                done;
  logic                ovf;

  always_comb begin
    diff     = {1'b0, rem, quo[QUOT_W-1]} - {2'b00, dvs};
    qbit     = ~diff[QUOT_W+1];
    rem_next = qbit ? diff[QUOT_W-1:0] : {rem[QUOT_W-2:0], quo[QUOT_W-1]};
  end

  assign res = {done, ovf, quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
      ovf    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            dvs <= divisor;
            // A high part at or above the divisor means a quotient of 2^32 or more.
            if (dividend[ACC_W-1:QUOT_W] >= (ACC_W-QUOT_W)'(divisor)) begin
              ovf  <= 1'b1;
              done <= 1'b1;
            end else begin
              ovf    <= 1'b0;
              rem    <= dividend[2*QUOT_W-1:QUOT_W];
              quo    <= dividend[QUOT_W-1:0];
              cnt    <= 5'd31;
              dstate <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem <= rem_next;
          quo <= {quo[QUOT_W-2:0], qbit};
          if (cnt == 5'd0) begin
            done   <= 1'b1;
            dstate <= D_IDLE;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

endmodule

>>> src/pd_filtered_derivative_controller.sv
// ----------------------------------------------------------------------------
// PD controller with filtered derivative
// Top level: request handshakes, sequencer, accumulator, clamp and history.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel carries setpoint, measured and restart, all
// signed Q16.16 except the restart flag. It is taken when in_valid and
// in_ready are both high. in_ready is high only while the sequencer is idle,
// so one request is worked on at a time. The result (drive and clamped)
// appears on the output channel and is held until out_ready takes it; a new
// request may be taken while that result still waits.
// Sequence: a general sample runs seven products through the shared
// multiplier, each through a multiply and an accumulate state, then a
// 32-step restoring division. A first sample (after reset or a restart)
// needs only one product. When the quotient cannot fit in 32 bits the
// division loop is skipped and the result is clamped. The next request
// is taken once the result is in the output register.
// Reset clears the history, marks the next sample as the first, and loads
// the register reset values. If the receiver stalls, the finished result
// waits inside the block until the output register is free.
// Configuration writes are always taken on the configuration channel.
// ----------------------------------------------------------------------------
module pd_filtered_derivative_controller import pdfd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] setpoint,
  input  logic signed [DATA_W-1:0] measured,
  input  logic                     restart,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] drive,
  output logic                     clamped,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [REG_W-1:0]         cfg_data
);

  localparam int STEP_W = 3;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_DIV, S_WAIT, S_DONE} state_t;

  // Product schedule. The general law needs the two combined gains first,
  // then the three numerator terms, the 64-bit gains split in two halves.
  typedef enum logic [STEP_W-1:0] {
    ST_G1, ST_G2, ST_UPREV, ST_E_LO, ST_E_HI, ST_PE_LO, ST_PE_HI, ST_FIRST
  } step_t;

  cfg_t     cfg;
  div_res_t div_res;

  state_t                    state;
  step_t                     step;
  logic                      first_sample;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   prev_error;
  logic signed [DATA_W-1:0]  prev_drive;
  logic [GAIN_W-1:0]         g1;
  logic [GAIN_W-1:0]         g2;
  logic [ACC_W-1:0]          acc;
  logic [QUOT_W-1:0]         quot;
  logic                      ovf;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  prod;
  logic [ERR_W-1:0]   err_mag;
  logic [ERR_W-1:0]   pe_mag;
  logic [DATA_W-1:0]  u_mag;
  logic [QUOT_W-1:0]  span;
  logic [GAIN_W-1:0]  kd_s;
  logic [ACC_W-1:0]   term;
  logic               tneg;
  logic [ACC_W-1:0]   addend;
  logic [ACC_W-1:0]   acc_mag;
  logic [ACC_W-1:0]   dividend;
  logic [QUOT_W-1:0]  divisor;
  logic               div_start;
  logic               over;
  logic [REG_W-1:0]   mag;
  logic [DATA_W-1:0]  drive_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign div_start = (state == S_DIV);

  pdfd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdfd_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  pdfd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .res      (div_res)
  );

  // Magnitudes of the signed operands; the multiplier works on magnitudes
  // and the sign is applied when the product is accumulated.
  always_comb begin
    err_mag = err[ERR_W-1] ? (~err + 1'b1) : err;
    pe_mag  = prev_error[ERR_W-1] ? (~prev_error + 1'b1) : prev_error;
    u_mag   = prev_drive[DATA_W-1] ? (~prev_drive + 1'b1) : prev_drive;
    span    = {1'b0, cfg.sample_period} + {1'b0, cfg.filter_time_const};
    kd_s    = GAIN_W'(cfg.deriv_gain) << FRAC_BITS;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step)
      ST_G1: begin
        mul_a = MUL_W'(cfg.prop_gain);
        mul_b = MUL_W'(span);
      end
      ST_G2: begin
        mul_a = MUL_W'(cfg.prop_gain);
        mul_b = MUL_W'(cfg.filter_time_const);
      end
      ST_UPREV: begin
        mul_a = MUL_W'(cfg.filter_time_const);
        mul_b = MUL_W'(u_mag);
      end
      ST_E_LO: begin
        mul_a = MUL_W'(g1[GAIN_W/2-1:0]);
        mul_b = err_mag;
      end
      ST_E_HI: begin
        mul_a = MUL_W'(g1[GAIN_W-1:GAIN_W/2]);
        mul_b = err_mag;
      end
      ST_PE_LO: begin
        mul_a = MUL_W'(g2[GAIN_W/2-1:0]);
        mul_b = pe_mag;
      end
      ST_PE_HI: begin
        mul_a = MUL_W'(g2[GAIN_W-1:GAIN_W/2]);
        mul_b = pe_mag;
      end
      ST_FIRST: begin
        mul_a = MUL_W'(cfg.prop_gain);
        mul_b = err_mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Alignment and sign of each numerator term. The previous-output term
  // carries the tau scale, the upper gain halves weigh 2^32, and the
  // previous-error term is subtracted.
  always_comb begin
    term = '0;
    tneg = 1'b0;
    case (step) inside
      ST_UPREV: begin
        term = ACC_W'(prod) << FRAC_BITS;
        tneg = prev_drive[DATA_W-1];
      end
      ST_E_LO, ST_FIRST: begin
        term = ACC_W'(prod);
        tneg = err[ERR_W-1];
      end
      ST_E_HI: begin
        term = ACC_W'(prod) << (GAIN_W/2);
        tneg = err[ERR_W-1];
      end
      ST_PE_LO: begin
        term = ACC_W'(prod);
        tneg = ~prev_error[ERR_W-1] && (prev_error != '0);
      end
      ST_PE_HI: begin
        term = ACC_W'(prod) << (GAIN_W/2);
        tneg = ~prev_error[ERR_W-1] && (prev_error != '0);
      end
      default: begin
        term = '0;
        tneg = 1'b0;
      end
    endcase
    addend = tneg ? (~term + 1'b1) : term;
  end

  // Division setup. Dividing by (span << F) equals dividing the magnitude
  // shifted right by F by span. A first sample divides by one, which leaves
  // the scaled product; a zero span is also taken as one.
  always_comb begin
    acc_mag  = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
    dividend = acc_mag >> FRAC_BITS;
    if ((step == ST_FIRST) || (span == '0)) begin
      divisor = QUOT_W'(1);
    end else begin
      divisor = span;
    end
  end

  // Clamp to the drive limit and apply the sign of the numerator.
  always_comb begin
    over      = ovf || (quot > QUOT_W'(cfg.drive_limit));
    mag       = over ? cfg.drive_limit : quot[REG_W-1:0];
    drive_val = acc[ACC_W-1] ? (~{1'b0, mag} + 1'b1) : {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= ST_G1;
      first_sample <= 1'b1;
      prev_error   <= '0;
      prev_drive   <= '0;
      out_valid    <= 1'b0;
    end else begin
      // A result that is taken while the next one is being loaded is
      // replaced in the finishing state below.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            err <= {setpoint[DATA_W-1], setpoint} - {measured[DATA_W-1], measured};
            if (restart) begin
              prev_error <= '0;
              prev_drive <= '0;
            end
            step         <= (first_sample || restart) ? ST_FIRST : ST_G1;
            first_sample <= 1'b0;
            acc          <= '0;
            state        <= S_MUL;
          end
        end
        S_MUL: begin
          // The product of the selected operands is registered at this edge.
          state <= S_ACC;
        end
        S_ACC: begin
          if (step == ST_G1) begin
            g1 <= prod[GAIN_W-1:0] + kd_s;
          end else if (step == ST_G2) begin
            g2 <= prod[GAIN_W-1:0] + kd_s;
          end else begin
            acc <= acc + addend;
          end
          if ((step == ST_PE_HI) || (step == ST_FIRST)) begin
            state <= S_DIV;
          end else begin
            step  <= step_t'(STEP_W'(step) + STEP_W'(1));
            state <= S_MUL;
          end
        end
        S_DIV: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_res.done) begin
            quot  <= div_res.quot;
            ovf   <= div_res.ovf;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            drive      <= drive_val;
            clamped    <= over;
            prev_error <= err;
            prev_drive <= drive_val;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
